>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and default widths of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DEF_DATA_WIDTH = 16;
	localparam int DEF_FRAC_BITS  = 12;
	localparam int FUNC_W         = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_MAG = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

endpackage

>>> rtl/core/cau_in_if.sv
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: function code and two complex operands.
// ----------------------------------------------------------------------------
interface cau_in_if #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic [cau_pkg::FUNC_W-1:0]        func;
	logic signed [DATA_WIDTH-1:0]      a_re;
	logic signed [DATA_WIDTH-1:0]      a_im;
	logic signed [DATA_WIDTH-1:0]      b_re;
	logic signed [DATA_WIDTH-1:0]      b_im;

	modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
	modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

>>> rtl/core/cau_out_if.sv
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status.
// ----------------------------------------------------------------------------
interface cau_out_if #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic signed [DATA_WIDTH-1:0]      res_re;
	logic signed [DATA_WIDTH-1:0]      res_im;
	logic [cau_pkg::STATUS_W-1:0]      status;

	modport source (output valid, res_re, res_im, status, input ready);
	modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

>>> rtl/core/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage, for two
// numerators sharing one divisor, with a side word carried alongside.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS,
	parameter int TAG_W      = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2*DATA_WIDTH:0]   num_re,
	input  logic [2*DATA_WIDTH:0]   num_im,
	input  logic [2*DATA_WIDTH:0]   den,
	input  logic [TAG_W-1:0]        tag_in,
	output logic                    out_valid,
	output logic [DATA_WIDTH:0]     q_re,
	output logic [DATA_WIDTH:0]     q_im,
	output logic                    ovf_re,
	output logic                    ovf_im,
	output logic [TAG_W-1:0]        tag_out
);
	localparam int W  = DATA_WIDTH;
	localparam int SW = 2 * W + 1;
	localparam int RW = SW + FRAC_BITS + W + 2;
	localparam int NS = W + 2;

	logic            vld_q  [NS];
	logic [RW-1:0]   rre_q  [NS];
	logic [RW-1:0]   rim_q  [NS];
	logic [W:0]      qre_q  [NS];
	logic [W:0]      qim_q  [NS];
	logic            ovre_q [NS];
	logic            ovim_q [NS];
	logic [SW-1:0]   den_q  [NS];
	logic [TAG_W-1:0] tag_q [NS];

	logic [RW-1:0] d_re, d_im, den_top;

	assign d_re    = RW'(num_re) << FRAC_BITS;
	assign d_im    = RW'(num_im) << FRAC_BITS;
	assign den_top = RW'(den) << (W + 1);

	// Entry stage: scale the numerators and flag quotients too large to fit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rre_q[0]  <= d_re;
			rim_q[0]  <= d_im;
			ovre_q[0] <= d_re >= den_top;
			ovim_q[0] <= d_im >= den_top;
			qre_q[0]  <= '0;
			qim_q[0]  <= '0;
			den_q[0]  <= den;
			tag_q[0]  <= tag_in;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          take_re, take_im;

		assign dsh     = RW'(den_q[j-1]) << (W + 1 - j);
		assign take_re = rre_q[j-1] >= dsh;
		assign take_im = rim_q[j-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_q[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rre_q[j]  <= take_re ? rre_q[j-1] - dsh : rre_q[j-1];
				rim_q[j]  <= take_im ? rim_q[j-1] - dsh : rim_q[j-1];
				qre_q[j]  <= {qre_q[j-1][W-1:0], take_re};
				qim_q[j]  <= {qim_q[j-1][W-1:0], take_im};
				ovre_q[j] <= ovre_q[j-1];
				ovim_q[j] <= ovim_q[j-1];
				den_q[j]  <= den_q[j-1];
				tag_q[j]  <= tag_q[j-1];
			end
		end
	end

	assign out_valid = vld_q[NS-1];
	assign q_re      = qre_q[NS-1];
	assign q_im      = qim_q[NS-1];
	assign ovf_re    = ovre_q[NS-1];
	assign ovf_im    = ovim_q[NS-1];
	assign tag_out   = tag_q[NS-1];

endmodule

>>> rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex fixed-point add, subtract, multiply, divide and squared magnitude.
// ----------------------------------------------------------------------------
// Every function takes the same path: operand registers, products, sums,
// the one-bit-per-stage divider pipeline and the output register.
// Throughput is one transfer per cycle; the whole pipeline holds when the
// result register is full and not taken, so in_ch.ready follows out_ch.
// Reset clears only the valid bits of the pipeline; data registers are free.
module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    in_ch,
	cau_out_if.source out_ch
);
	import cau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	// Side word through the divider: func, zero divisor, and the
	// sign-magnitude results of the other functions and the quotient signs.
	localparam int TAG_W = FUNC_W + 1 + 2 * (SW + 1) + 2;

	// A single enable moves every stage together, so a stall neither drops
	// nor repeats a transfer.
	logic en;
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: operand registers.
	logic                 v_s1;
	logic [FUNC_W-1:0]    func_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= in_ch.func;
			ar_s1   <= in_ch.a_re;
			ai_s1   <= in_ch.a_im;
			br_s1   <= in_ch.b_re;
			bi_s1   <= in_ch.b_im;
		end
	end

	// Stage 2: the six partial products, plus the plain sum or difference.
	// For the squared magnitude the first two multipliers square a.
	logic                 v_s2;
	logic [FUNC_W-1:0]    func_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [W:0]    as_s2;
	logic signed [W-1:0]  m0b, m1b;
	logic                 is_mag_s1;

	assign is_mag_s1 = func_s1 == FUNC_MAG;
	assign m0b       = is_mag_s1 ? ar_s1 : br_s1;
	assign m1b       = is_mag_s1 ? ai_s1 : bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			p0_s2   <= PW'(ar_s1) * PW'(m0b);
			p1_s2   <= PW'(ai_s1) * PW'(m1b);
			p2_s2   <= PW'(ar_s1) * PW'(bi_s1);
			p3_s2   <= PW'(ai_s1) * PW'(br_s1);
			p4_s2   <= PW'(br_s1) * PW'(br_s1);
			p5_s2   <= PW'(bi_s1) * PW'(bi_s1);
			if (func_s1 == FUNC_SUB) begin
				as_s2 <= {ar_s1[W-1], ar_s1} - {br_s1[W-1], br_s1};
			end else begin
				as_s2 <= {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
			end
		end
	end

	// The imaginary part of the sum or difference is formed one stage later
	// from the same registered operands carried along.
	logic signed [W-1:0] ai_s2, bi_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ai_s2 <= ai_s1;
			bi_s2 <= bi_s1;
		end
	end

	// Stage 3: sums of products at full precision, the sum or difference, and the divisor.
	logic                 v_s3;
	logic [FUNC_W-1:0]    func_s3;
	logic signed [SW-1:0] sre_s3, sim_s3;
	logic [SW-1:0]        den_s3;
	logic signed [SW-1:0] e0, e1, e2, e3;

	assign e0 = SW'(p0_s2);
	assign e1 = SW'(p1_s2);
	assign e2 = SW'(p2_s2);
	assign e3 = SW'(p3_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			den_s3  <= SW'(p4_s2) + SW'(p5_s2);
			case (func_s2)
				FUNC_ADD: begin
					sre_s3 <= SW'(as_s2);
					sim_s3 <= SW'(ai_s2) + SW'(bi_s2);
				end
				FUNC_SUB: begin
					sre_s3 <= SW'(as_s2);
					sim_s3 <= SW'(ai_s2) - SW'(bi_s2);
				end
				FUNC_MUL: begin
					sre_s3 <= e0 - e1;
					sim_s3 <= e2 + e3;
				end
				FUNC_DIV: begin
					sre_s3 <= e0 + e1;
					sim_s3 <= e3 - e2;
				end
				default: begin
					sre_s3 <= e0 + e1;
					sim_s3 <= '0;
				end
			endcase
		end
	end

	// Sign-magnitude form; products and the squared magnitude are truncated
	// toward zero by shifting the magnitude.
	logic          neg_re, neg_im;
	logic [SW-1:0] mag_re, mag_im, tm_re, tm_im;
	logic          is_prod_s3;

	assign neg_re     = sre_s3[SW-1];
	assign neg_im     = sim_s3[SW-1];
	assign mag_re     = neg_re ? SW'(-sre_s3) : SW'(sre_s3);
	assign mag_im     = neg_im ? SW'(-sim_s3) : SW'(sim_s3);
	assign is_prod_s3 = func_s3 inside {FUNC_MUL, FUNC_MAG};
	assign tm_re      = is_prod_s3 ? mag_re >> FRAC_BITS : mag_re;
	assign tm_im      = is_prod_s3 ? mag_im >> FRAC_BITS : mag_im;

	logic [TAG_W-1:0] tag_in, tag_out;
	logic             dv;
	logic [W:0]       q_re, q_im;
	logic             ovf_re, ovf_im;

	assign tag_in = {func_s3, den_s3 == '0, neg_re, tm_re, neg_im, tm_im, neg_re, neg_im};

	cau_div #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.TAG_W      (TAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num_re    (mag_re),
		.num_im    (mag_im),
		.den       (den_s3),
		.tag_in    (tag_in),
		.out_valid (dv),
		.q_re      (q_re),
		.q_im      (q_im),
		.ovf_re    (ovf_re),
		.ovf_im    (ovf_im),
		.tag_out   (tag_out)
	);

	logic [FUNC_W-1:0] t_func;
	logic              t_dz, t_nre, t_nim, t_qnre, t_qnim;
	logic [SW-1:0]     t_mre, t_mim;

	assign {t_func, t_dz, t_nre, t_mre, t_nim, t_mim, t_qnre, t_qnim} = tag_out;

	// Clamp a sign-magnitude value to the signed range; the top bit of the
	// result says whether it saturated. The most negative value is exact.
	function automatic logic [W:0] clamp_sm(input logic [SW-1:0] mag, input logic neg);
		logic [SW-1:0] lim;
		logic [W-1:0]  val;
		logic          sat;
		lim = SW'(1) << (W - 1);
		sat = 1'b0;
		if (neg) begin
			if (mag >= lim) begin
				val = {1'b1, {(W-1){1'b0}}};
				sat = mag > lim;
			end else begin
				val = -mag[W-1:0];
			end
		end else if (mag >= lim) begin
			val = {1'b0, {(W-1){1'b1}}};
			sat = 1'b1;
		end else begin
			val = mag[W-1:0];
		end
		return {sat, val};
	endfunction

	logic [SW-1:0] dm_re, dm_im;
	logic [W:0]    c_re, c_im;
	logic [W-1:0]  r_re, r_im;
	logic [STATUS_W-1:0] st;

	// A quotient flagged too large is given an out-of-range magnitude.
	assign dm_re = ovf_re ? '1 : SW'(q_re);
	assign dm_im = ovf_im ? '1 : SW'(q_im);

	always_comb begin
		c_re = '0;
		c_im = '0;
		st   = ST_OK;
		case (t_func)
			FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
				c_re = clamp_sm(t_mre, t_nre);
				c_im = clamp_sm(t_mim, t_nim);
			end
			FUNC_DIV: begin
				if (!t_dz) begin
					c_re = clamp_sm(dm_re, t_qnre);
					c_im = clamp_sm(dm_im, t_qnim);
				end
			end
			FUNC_MAG: begin
				c_re = clamp_sm(t_mre, 1'b0);
			end
			default: begin
			end
		endcase
		r_re = c_re[W-1:0];
		r_im = c_im[W-1:0];
		if (t_func == FUNC_DIV && t_dz) begin
			st = ST_DIVZ;
		end else if (c_re[W] || c_im[W]) begin
			st = ST_SAT;
		end
	end

	// Output register.
	logic                vo_q;
	logic signed [W-1:0] re_q, im_q;
	logic [STATUS_W-1:0] st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q <= r_re;
			im_q <= r_im;
			st_q <= st;
		end
	end

	assign out_ch.valid  = vo_q;
	assign out_ch.res_re = re_q;
	assign out_ch.res_im = im_q;
	assign out_ch.status = st_q;

endmodule

>>> rtl/core/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [DATA_WIDTH-1:0]        res_re,
	input logic [DATA_WIDTH-1:0]        res_im,
	input logic [cau_pkg::STATUS_W-1:0] status
);
	import cau_pkg::*;

	// A stalled result stays offered with the same value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
			&& $stable(status))
		else $error("result changed while stalled");

	// The input is refused only while a result waits to be taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output side");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIVZ |-> res_re == '0 && res_im == '0)
		else $error("division by zero gave a non-zero result");

endmodule

bind complex_arith_unit cau_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.res_re    (out_ch.res_re),
	.res_im    (out_ch.res_im),
	.status    (out_ch.status)
);
